/* hw/rtl/ipr_pkg.sv */
// Shared types and constants for the Rubin pooling block.
// No dependencies; imported by the divider, the root unit and the top level.
`default_nettype none
package ipr_pkg;

	localparam logic [63:0] ALL64   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
	localparam int          ESUM_W  = 48;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_NO_VALID = 3'd1;
	localparam logic [2:0] STAT_ONE      = 3'd2;
	localparam logic [2:0] STAT_ZERO_B   = 3'd3;
	localparam logic [2:0] STAT_OVF      = 3'd4;

	// Result of the shared divider: done pulses for one cycle.
	typedef struct packed {
		logic        done;
		logic        sat;
		logic [63:0] quo;
	} div_res_t;

	typedef struct packed {
		logic        done;
		logic [31:0] root;
	} sqrt_res_t;

endpackage
`default_nettype wire

/* hw/rtl/ipr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ipr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* hw/rtl/ipr_div.sv */
// Radix-2 restoring divider: 128-bit numerator and denominator, quotient
// rounded half up and saturated to 64 bits. Depends on ipr_pkg.
`default_nettype none
module ipr_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [127:0]     num,
	input  logic [127:0]     den,
	output logic             busy,
	output ipr_pkg::div_res_t res
);
	import ipr_pkg::*;

	logic [127:0] n_q, d_q, rem_q, q_q;
	logic [6:0]   cnt_q;
	logic         run_q, fin_q, done_q;
	logic [63:0]  quo_q;
	logic         sat_q;

	logic [128:0] rem_sh, rem_nx;
	logic         ge;
	logic [128:0] two_rem;
	logic         rnd;
	logic [128:0] q_rnd;

	assign rem_sh  = {rem_q, n_q[127]};
	assign ge      = rem_sh >= {1'b0, d_q};
	assign rem_nx  = ge ? rem_sh - {1'b0, d_q} : rem_sh;
	assign two_rem = {rem_q, 1'b0};
	assign rnd     = two_rem >= {1'b0, d_q};
	assign q_rnd   = {1'b0, q_q} + {128'b0, rnd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= run_q && !start && (cnt_q == 7'd127);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
			q_q   <= '0;
		end else if (run_q) begin
			n_q   <= {n_q[126:0], 1'b0};
			rem_q <= rem_nx[127:0];
			q_q   <= {q_q[126:0], ge};
		end
		if (fin_q) begin
			sat_q <= |q_rnd[128:64];
			quo_q <= (|q_rnd[128:64]) ? ALL64 : q_rnd[63:0];
		end
	end

	assign busy     = run_q | fin_q | done_q;
	assign res.done = done_q;
	assign res.sat  = sat_q;
	assign res.quo  = quo_q;

endmodule
`default_nettype wire

/* hw/rtl/ipr_sqrt.sv */
// Digit-by-digit integer square root of a 64-bit value, one result bit
// per cycle. Depends on ipr_pkg.
`default_nettype none
module ipr_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [63:0]       value,
	output ipr_pkg::sqrt_res_t res
);
	import ipr_pkg::*;

	logic [63:0] v_q, r_q, bit_q;
	logic [4:0]  cnt_q;
	logic        run_q, done_q;
	logic [63:0] rb;

	assign rb = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && !start && (cnt_q == 5'd31);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (run_q) begin
			if (v_q >= rb) begin
				v_q <= v_q - rb;
				r_q <= {1'b0, r_q[63:1]} + bit_q;
			end else begin
				r_q <= {1'b0, r_q[63:1]};
			end
			bit_q <= {2'b00, bit_q[63:2]};
		end
	end

	assign res.done = done_q;
	assign res.root = r_q[31:0];

endmodule
`default_nettype wire

/* hw/rtl/imputation_pooling_rubin.sv */
// Rubin's rules pooling of multiple-imputation estimates, fixed point.
// Depends on ipr_pkg, ipr_ram, ipr_div and ipr_sqrt.
//
// Input items arrive on s_t*: beta and std_error in s_tdata, the missing
// flag in s_tuser, the end of a set in s_tlast. Each item is registered,
// then stored in the effect memory and added to the sums; no new item is
// accepted meanwhile. An item with s_tlast closes the set and starts the
// finishing sequence: mean and within variance divisions, one pass over
// the effect memory for the between sum, further divisions for B, B/m
// and the degrees of freedom, a 64x64 product, a square root and the t
// division. s_tready is low during the finishing sequence.
// One result item per set leaves on m_t*, status in m_tuser. The result
// sits in an output register, so a stalled receiver blocks the block only
// when the next set finishes before the previous result was taken.
// Reset clears the sums, the count and the output valid; the effect memory
// needs no clearing since only entries written in the current set are read.
`default_nettype none
module imputation_pooling_rubin #(
	parameter int MAX_IMPUTATIONS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,  // beta, std_error
	input  logic         s_tuser,  // beta_missing
	input  logic         s_tlast,  // last
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [327:0] m_tdata,  // pooled count, mean effect, within var,
	                               // between var, total var,
	                               // degrees of freedom, t statistic, pad
	output logic [2:0]   m_tuser   // status
);
	import ipr_pkg::*;

	localparam int CW = $clog2(MAX_IMPUTATIONS + 1);
	localparam int AW = $clog2(MAX_IMPUTATIONS);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_IMPUTATIONS);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MEAN  = 4'd1;
	localparam logic [3:0] ST_WDIV  = 4'd2;
	localparam logic [3:0] ST_PASS  = 4'd3;
	localparam logic [3:0] ST_BDIV  = 4'd4;
	localparam logic [3:0] ST_BMDIV = 4'd5;
	localparam logic [3:0] ST_TPOOL = 4'd6;
	localparam logic [3:0] ST_XDIV  = 4'd7;
	localparam logic [3:0] ST_FMUL  = 4'd8;
	localparam logic [3:0] ST_GG    = 4'd9;
	localparam logic [3:0] ST_DOF   = 4'd10;
	localparam logic [3:0] ST_SQRT  = 4'd11;
	localparam logic [3:0] ST_TDIV  = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;

	logic [3:0]  state_q;
	logic        ld_q, wait_q;
	logic [31:0] beta_s1, se_s1;
	logic        miss_s1, last_s1;

	logic [CW-1:0]            cnt_q;
	logic signed [ESUM_W-1:0] esum_q;
	logic [63:0]              sqsum_q;
	logic                     ovf_q, sat_q, neg_q;

	logic signed [31:0] mean_q;
	logic [31:0]        am_q;
	logic [63:0]        w_q, b_q, tp_q, dof_q, f_q, gg_q, bsum_q;
	logic [127:0]       ff_q;
	logic [63:0]        prod_s;
	logic [1:0]         sh_s;
	logic               pv_s;
	logic [2:0]         mk_q;
	logic [31:0]        s_q, t_q;

	logic [CW-1:0] pa_q;
	logic          rv_s1, dv_s2;
	logic [31:0]   dm_s2;

	logic          o_valid_q;
	logic [327:0]  o_data_q;
	logic [2:0]    o_user_q;

	// Load path
	logic [63:0]   sq_prod;
	logic [64:0]   sq_add;
	logic          ram_we;
	logic [31:0]   ram_rdata;

	// Between pass
	logic          issue;
	logic [33:0]   dif;
	logic [33:0]   dif_abs;
	logic [63:0]   bsq;
	logic [64:0]   bsum_add;

	// Divider and root
	logic          div_start, div_busy;
	logic [127:0]  div_num, div_den;
	div_res_t      div_res;
	logic          sqrt_start;
	sqrt_res_t     sqrt_res;

	logic [CW-1:0]    m_minus1;
	logic [CW:0]      m_plus1;
	logic [63+CW:0]   wm;
	logic [64+CW:0]   bm1;
	logic [ESUM_W-1:0] mag;
	logic [64:0]      bb_add, tp_add, f_add;
	logic [31:0]      fa, fb;
	logic [127:0]     prod_sh;
	logic [96:0]      ggw;
	logic [63+CW:0]   g;
	logic [32:0]      lim;
	logic [31:0]      tq;
	logic             tclamp;
	logic             out_free;
	logic [2:0]       status;

	assign s_tready = (state_q == ST_IDLE) && !ld_q;

	assign sq_prod = se_s1 * se_s1;
	assign sq_add  = {1'b0, sqsum_q} + {1'b0, sq_prod};
	assign ram_we  = ld_q && !miss_s1 && (cnt_q < MAX_CNT);

	ipr_ram #(.WIDTH(32), .DEPTH(MAX_IMPUTATIONS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (beta_s1),
		.raddr (pa_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign issue    = (state_q == ST_PASS) && (pa_q < cnt_q);
	assign dif      = {{2{ram_rdata[31]}}, ram_rdata} - {{2{mean_q[31]}}, mean_q};
	assign dif_abs  = dif[33] ? -dif : dif;
	assign bsq      = dm_s2 * dm_s2;
	assign bsum_add = {1'b0, bsum_q} + {1'b0, bsq};

	assign m_minus1 = cnt_q - CW'(1);
	assign m_plus1  = {1'b0, cnt_q} + (CW+1)'(1);
	assign wm       = w_q * cnt_q;
	assign bm1      = b_q * m_plus1;
	assign mag      = esum_q[ESUM_W-1] ? -esum_q : esum_q;

	always_comb begin
		div_num = '0;
		div_den = {{(128-CW){1'b0}}, cnt_q};
		case (state_q)
			ST_MEAN:  div_num = {{(128-ESUM_W){1'b0}}, mag};
			ST_WDIV:  div_num = {64'b0, sqsum_q};
			ST_BDIV: begin
				div_num = {64'b0, bsum_q};
				div_den = {{(128-CW){1'b0}}, m_minus1};
			end
			ST_BMDIV: div_num = {64'b0, b_q};
			ST_XDIV: begin
				div_num = {{(32-CW){1'b0}}, wm, 32'b0};
				div_den = {{(63-CW){1'b0}}, bm1};
			end
			ST_TDIV: begin
				div_num = {80'b0, am_q, 16'b0};
				div_den = {96'b0, s_q};
			end
			default: div_num = '0;
		endcase
	end

	assign div_start = !wait_q && (
		(state_q == ST_MEAN && cnt_q != '0) || state_q == ST_WDIV ||
		state_q == ST_BDIV || state_q == ST_BMDIV || state_q == ST_XDIV ||
		(state_q == ST_TDIV && am_q != '0 && s_q != '0));

	ipr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.res    (div_res)
	);

	assign sqrt_start = (state_q == ST_SQRT) && !wait_q;

	ipr_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (tp_q),
		.res    (sqrt_res)
	);

	assign bb_add = {1'b0, b_q} + {1'b0, div_res.quo};
	assign tp_add = {1'b0, w_q} + {1'b0, tp_q};
	assign f_add  = {1'b0, div_res.quo} + {1'b0, ONE_Q32};
	assign fa     = mk_q[1] ? f_q[63:32] : f_q[31:0];
	assign fb     = mk_q[0] ? f_q[63:32] : f_q[31:0];
	assign ggw    = {1'b0, ff_q[127:32]} + {96'b0, ff_q[31]};
	assign g      = gg_q * m_minus1;
	assign lim    = neg_q ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
	assign tclamp = div_res.quo > {31'b0, lim};
	assign tq     = tclamp ? lim[31:0] : div_res.quo[31:0];
	assign out_free = !o_valid_q || m_tready;

	always_comb begin
		case (sh_s)
			2'd0:    prod_sh = {64'b0, prod_s};
			2'd1:    prod_sh = {32'b0, prod_s, 32'b0};
			default: prod_sh = {prod_s, 64'b0};
		endcase
	end

	always_comb begin
		if (cnt_q == '0) begin
			status = STAT_NO_VALID;
		end else if (cnt_q == CW'(1)) begin
			status = STAT_ONE;
		end else if (b_q == '0) begin
			status = STAT_ZERO_B;
		end else if (sat_q) begin
			status = STAT_OVF;
		end else begin
			status = STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ld_q      <= 1'b0;
			wait_q    <= 1'b0;
			cnt_q     <= '0;
			esum_q    <= '0;
			sqsum_q   <= '0;
			ovf_q     <= 1'b0;
			sat_q     <= 1'b0;
			neg_q     <= 1'b0;
			pa_q      <= '0;
			rv_s1     <= 1'b0;
			dv_s2     <= 1'b0;
			pv_s      <= 1'b0;
			mk_q      <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (m_tready && state_q != ST_OUT) begin
				o_valid_q <= 1'b0;
			end
			ld_q <= s_tvalid && s_tready;

			case (state_q)
				ST_IDLE: begin
					if (ld_q) begin
						if (!miss_s1) begin
							if (cnt_q >= MAX_CNT) begin
								ovf_q <= 1'b1;
							end else begin
								cnt_q  <= cnt_q + CW'(1);
								esum_q <= esum_q + ESUM_W'($signed(beta_s1));
								if (sq_add[64]) begin
									sqsum_q <= ALL64;
									ovf_q   <= 1'b1;
								end else begin
									sqsum_q <= sq_add[63:0];
								end
							end
						end
						if (last_s1) begin
							state_q <= ST_MEAN;
						end
					end
				end
				ST_MEAN: begin
					sat_q <= ovf_q;
					neg_q <= esum_q[ESUM_W-1];
					if (cnt_q == '0) begin
						mean_q  <= '0;
						w_q     <= '0;
						b_q     <= '0;
						tp_q    <= '0;
						dof_q   <= '0;
						t_q     <= '0;
						state_q <= ST_OUT;
					end else if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_res.done) begin
						wait_q  <= 1'b0;
						am_q    <= div_res.quo[31:0];
						mean_q  <= neg_q ? -div_res.quo[31:0] : div_res.quo[31:0];
						state_q <= ST_WDIV;
					end
				end
				ST_WDIV: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_res.done) begin
						wait_q <= 1'b0;
						w_q    <= div_res.quo;
						sat_q  <= sat_q | div_res.sat;
						bsum_q <= '0;
						pa_q   <= '0;
						if (cnt_q == CW'(1)) begin
							b_q     <= '0;
							state_q <= ST_BMDIV;
						end else begin
							state_q <= ST_PASS;
						end
					end
				end
				ST_PASS: begin
					if (issue) begin
						pa_q <= pa_q + CW'(1);
					end
					if (pa_q == cnt_q && !rv_s1 && !dv_s2) begin
						state_q <= ST_BDIV;
					end
				end
				ST_BDIV: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_res.done) begin
						wait_q  <= 1'b0;
						b_q     <= div_res.quo;
						sat_q   <= sat_q | div_res.sat;
						state_q <= ST_BMDIV;
					end
				end
				ST_BMDIV: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_res.done) begin
						wait_q  <= 1'b0;
						tp_q    <= bb_add[64] ? ALL64 : bb_add[63:0];
						sat_q   <= sat_q | div_res.sat | bb_add[64];
						state_q <= ST_TPOOL;
					end
				end
				ST_TPOOL: begin
					tp_q  <= tp_add[64] ? ALL64 : tp_add[63:0];
					sat_q <= sat_q | tp_add[64];
					if (cnt_q == CW'(1)) begin
						dof_q   <= '0;
						state_q <= ST_SQRT;
					end else if (b_q == '0) begin
						dof_q   <= ALL64;
						state_q <= ST_SQRT;
					end else begin
						state_q <= ST_XDIV;
					end
				end
				ST_XDIV: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_res.done) begin
						wait_q  <= 1'b0;
						f_q     <= f_add[64] ? ALL64 : f_add[63:0];
						sat_q   <= sat_q | div_res.sat | f_add[64];
						ff_q    <= '0;
						mk_q    <= '0;
						pv_s    <= 1'b0;
						state_q <= ST_FMUL;
					end
				end
				ST_FMUL: begin
					// Four 32x32 partial products, each registered and accumulated in the following cycle.
					if (mk_q != 3'd4) begin
						prod_s <= fa * fb;
						sh_s   <= 2'(mk_q[1]) + 2'(mk_q[0]);
						pv_s   <= 1'b1;
						mk_q   <= mk_q + 3'd1;
					end else begin
						pv_s    <= 1'b0;
						state_q <= ST_GG;
					end
					if (pv_s) begin
						ff_q <= ff_q + prod_sh;
					end
				end
				ST_GG: begin
					if (|ggw[96:64]) begin
						gg_q  <= ALL64;
						sat_q <= 1'b1;
					end else begin
						gg_q <= ggw[63:0];
					end
					state_q <= ST_DOF;
				end
				ST_DOF: begin
					if (|g[63+CW:64]) begin
						dof_q <= ALL64;
						sat_q <= 1'b1;
					end else begin
						dof_q <= g[63:0];
					end
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (sqrt_res.done) begin
						wait_q  <= 1'b0;
						s_q     <= sqrt_res.root;
						state_q <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					if (am_q == '0) begin
						t_q     <= '0;
						state_q <= ST_OUT;
					end else if (s_q == '0) begin
						t_q     <= neg_q ? -lim[31:0] : lim[31:0];
						sat_q   <= 1'b1;
						state_q <= ST_OUT;
					end else if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_res.done) begin
						wait_q  <= 1'b0;
						t_q     <= neg_q ? -tq : tq;
						sat_q   <= sat_q | div_res.sat | tclamp;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						o_valid_q <= 1'b1;
						o_user_q  <= status;
						o_data_q  <= {1'b0, t_q, dof_q, tp_q, b_q, w_q, mean_q,
						              7'(cnt_q)};
						cnt_q     <= '0;
						esum_q    <= '0;
						sqsum_q   <= '0;
						ovf_q     <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// Between pass pipeline: memory read, difference, square and sum.
			rv_s1 <= issue;
			dv_s2 <= rv_s1;
			if (rv_s1) begin
				dm_s2 <= dif_abs[31:0];
			end
			if (dv_s2) begin
				if (bsum_add[64]) begin
					bsum_q <= ALL64;
					sat_q  <= 1'b1;
				end else begin
					bsum_q <= bsum_add[63:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beta_s1 <= s_tdata[31:0];
			se_s1   <= s_tdata[63:32];
			miss_s1 <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = o_data_q;
	assign m_tuser  = o_user_q;

	a_load_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		ld_q |-> !s_tready)
		else $error("input accepted while an item was still being loaded");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("valid item count exceeds the store depth");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_out_clears_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (o_valid_q && cnt_q == '0))
		else $error("result not posted or set not cleared");

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for imputation_pooling_rubin: a directed table, then random
// imputation sets, checked against a fixed-point Rubin's rules predictor or, for typed
// rows, against the table's result. Depends on ipr_pkg and the RTL of the pooling block.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ipr_pkg::*;

	localparam int STORE_DEPTH = 64;
	localparam int HOLD_CYCLES = 4000;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  count;
		logic [31:0] mean;
		logic [63:0] w_var;
		logic [63:0] between;
		logic [63:0] total;
		logic [63:0] dof;
		logic [31:0] tstat;
	} pooled_t;

	typedef struct {
		logic [31:0] beta;
		logic [31:0] se;
		bit          miss;
		bit          last;
		bit          typed;
		pooled_t     res;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [327:0] m_tdata;
	logic [2:0]   m_tuser;

	// Predictor state for the set being collected.
	logic signed [31:0] effects [STORE_DEPTH];
	longint             effect_total;
	logic [63:0]        se_square_total;
	int                 pooled_count;
	bit                 store_overflow;

	pooled_t pending_pools[$];
	int      errors = 0;
	int      pools_seen = 0;
	int      items_sent = 0;
	bit      quiet = 1'b0;

	imputation_pooling_rubin u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// Rounded quotient, halves away from zero, saturated to 64 bits.
	function automatic logic [63:0] round_div(input logic [127:0] n, input logic [127:0] d,
			inout bit sat);
		logic [128:0] q;
		logic [128:0] r;
		q = n / d;
		r = n % d;
		if ((r << 1) >= {1'b0, d})
			q = q + 129'd1;
		if (q[128:64] != 0) begin
			sat = 1'b1;
			return ALL64;
		end
		return q[63:0];
	endfunction

	function automatic logic [63:0] add_clip(input logic [63:0] a, input logic [63:0] b,
			inout bit sat);
		logic [64:0] s;
		s = a + b;
		if (s[64]) begin
			sat = 1'b1;
			return ALL64;
		end
		return s[63:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v = v - (r + bitv);
				r = (r >> 1) + bitv;
			end else
				r = r >> 1;
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	// Folds one accepted item into the set; on the closing item returns the pooled result.
	task automatic pool_item(input logic [31:0] beta, input logic [31:0] se, input bit miss,
			input bit last, output bit closes, output pooled_t r);
		logic [64:0]  acc;
		logic [63:0]  m, mag, q, w, b, tp, dof, bsum, dm, x, f, gg, s, am, lim, tq;
		logic [127:0] num, g;
		longint       mean, d;
		bit           sat, neg;
		closes = 1'b0;
		r = '0;
		if (!miss) begin
			if (pooled_count >= STORE_DEPTH)
				store_overflow = 1'b1;
			else begin
				effects[pooled_count] = beta;
				pooled_count++;
				effect_total += longint'($signed(beta));
				acc = se_square_total + {32'd0, se} * {32'd0, se};
				if (acc[64]) begin
					se_square_total = ALL64;
					store_overflow = 1'b1;
				end else
					se_square_total = acc[63:0];
			end
		end
		if (!last)
			return;
		closes = 1'b1;
		m = 64'(pooled_count);
		sat = store_overflow;
		w = 0; b = 0; tp = 0; dof = 0; mean = 0; tq = 0; neg = 1'b0;
		if (m >= 1) begin
			neg = effect_total < 0;
			mag = neg ? -effect_total : effect_total;
			q = round_div(mag, m, sat);
			mean = neg ? -longint'(q) : longint'(q);
			w = round_div(se_square_total, m, sat);
			if (m >= 2) begin
				bsum = 0;
				for (int i = 0; i < pooled_count; i++) begin
					d = longint'(effects[i]) - mean;
					dm = d < 0 ? -d : d;
					bsum = add_clip(bsum, dm * dm, sat);
				end
				b = round_div(bsum, m - 1, sat);
			end
			tp = add_clip(w, add_clip(b, round_div(b, m, sat), sat), sat);
			if (m >= 2) begin
				if (b == 0)
					dof = ALL64;
				else begin
					num = ({64'd0, w} * {64'd0, m}) << 32;
					x = round_div(num, {64'd0, b} * {64'd0, m + 1}, sat);
					f = add_clip(x, ONE_Q32, sat);
					gg = round_div({64'd0, f} * {64'd0, f}, {64'd0, ONE_Q32}, sat);
					g = {64'd0, gg} * {64'd0, m - 1};
					if (g[127:64] != 0) begin
						sat = 1'b1;
						dof = ALL64;
					end else
						dof = g[63:0];
				end
			end
			s = floor_sqrt(tp);
			am = neg ? -mean : mean;
			lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
			if (am == 0)
				tq = 0;
			else if (s == 0) begin
				tq = lim;
				sat = 1'b1;
			end else begin
				tq = round_div(am << 16, s, sat);
				if (tq > lim) begin
					tq = lim;
					sat = 1'b1;
				end
			end
		end
		if (m == 0)
			r.status = STAT_NO_VALID;
		else if (m == 1)
			r.status = STAT_ONE;
		else if (b == 0)
			r.status = STAT_ZERO_B;
		else if (sat)
			r.status = STAT_OVF;
		else
			r.status = STAT_OK;
		r.count = m[6:0];
		r.mean = mean[31:0];
		r.w_var = w;
		r.between = b;
		r.total = tp;
		r.dof = dof;
		r.tstat = neg ? 32'(-tq) : tq[31:0];
		effect_total = 0;
		se_square_total = 0;
		pooled_count = 0;
		store_overflow = 1'b0;
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic send_item(input row_t it);
		bit      closes;
		pooled_t r;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {it.se, it.beta};
		s_tuser <= it.miss;
		s_tlast <= it.last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		pool_item(it.beta, it.se, it.miss, it.last, closes, r);
		if (closes)
			pending_pools.push_back(it.typed ? it.res : r);
	endtask

	function automatic row_t mk(input logic [31:0] beta, input logic [31:0] se, input bit miss,
			input bit last);
		row_t it;
		it.beta = beta;
		it.se = se;
		it.miss = miss;
		it.last = last;
		it.typed = 1'b0;
		it.res = '0;
		return it;
	endfunction

	function automatic row_t mk_typed(input logic [31:0] beta, input logic [31:0] se,
			input bit miss, input pooled_t res);
		row_t it;
		it = mk(beta, se, miss, 1'b1);
		it.typed = 1'b1;
		it.res = res;
		return it;
	endfunction

	function automatic logic [31:0] rand_beta(input bit wide);
		if (wide)
			return $urandom;
		return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
	endfunction

	function automatic logic [31:0] rand_se(input bit wide);
		if (wide)
			return $urandom;
		return $urandom_range(0, 32'h0003_0000);
	endfunction

	// Output side: stalls in short bursts, and once holds off long enough to back up the input.
	initial begin : receiver
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && pools_seen == 8) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pooled_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			pools_seen++;
			got.status = m_tuser;
			{got.tstat, got.dof, got.total, got.between, got.w_var, got.mean, got.count} =
				m_tdata[326:0];
			if (pending_pools.size() == 0) begin
				report("unexpected result", 64'(m_tuser), 64'd0);
			end else begin
				want = pending_pools.pop_front();
				if (got.status !== want.status) report("status", got.status, want.status);
				if (got.count !== want.count) report("pooled count", got.count, want.count);
				if (got.mean !== want.mean) report("mean effect", got.mean, want.mean);
				if (got.w_var !== want.w_var) report("within var", got.w_var, want.w_var);
				if (got.between !== want.between)
					report("between var", got.between, want.between);
				if (got.total !== want.total) report("total var", got.total, want.total);
				if (got.dof !== want.dof) report("degrees of freedom", got.dof, want.dof);
				if (got.tstat !== want.tstat) report("t statistic", got.tstat, want.tstat);
			end
		end
	end

	initial begin : watchdog
		#30ms;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin : stimulus
		row_t    table_rows[$];
		pooled_t e;
		int      len, kind;
		bit      wide, same;
		logic [31:0] fixed_beta;
		effect_total = 0;
		se_square_total = 0;
		pooled_count = 0;
		store_overflow = 1'b0;

		// Set with no valid estimate.
		e = '0; e.status = STAT_NO_VALID;
		table_rows.push_back(mk_typed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, e));
		// One valid estimate of zero.
		e = '0; e.status = STAT_ONE; e.count = 7'd1;
		table_rows.push_back(mk_typed(32'd0, 32'd0, 1'b0, e));
		// Two equal effects of 1.0 with error 1.0: no between variance.
		table_rows.push_back(mk(32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0));
		e = '0; e.status = STAT_ZERO_B; e.count = 7'd2; e.mean = 32'h0001_0000;
		e.w_var = ONE_Q32; e.total = ONE_Q32; e.dof = ALL64; e.tstat = 32'h0001_0000;
		table_rows.push_back(mk_typed(32'h0001_0000, 32'h0001_0000, 1'b0, e));
		// One negative estimate with zero error: t saturates to the negative limit.
		e = '0; e.status = STAT_ONE; e.count = 7'd1; e.mean = 32'hFFFF_0000;
		e.tstat = 32'h8000_0000;
		table_rows.push_back(mk_typed(32'hFFFF_0000, 32'd0, 1'b0, e));
		// Missing item inside a set.
		table_rows.push_back(mk(32'hFFFE_0000, 32'd0, 1'b0, 1'b0));
		table_rows.push_back(mk(32'h1234_5678, 32'h0000_4000, 1'b1, 1'b0));
		table_rows.push_back(mk(32'h0002_0000, 32'h0000_8000, 1'b0, 1'b1));
		// Effect and error extremes; the squared errors saturate their sum.
		table_rows.push_back(mk(32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0));
		table_rows.push_back(mk(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
		// A missing item closes a set of valid ones.
		table_rows.push_back(mk(32'h0003_0000, 32'h0000_8000, 1'b0, 1'b0));
		table_rows.push_back(mk(32'h0001_0000, 32'h0000_4000, 1'b0, 1'b0));
		table_rows.push_back(mk(32'hFFFF_8000, 32'h0001_8000, 1'b0, 1'b0));
		table_rows.push_back(mk(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1));
		// Small spread with large errors, a wide degrees of freedom.
		table_rows.push_back(mk(32'h0001_0000, 32'h0100_0000, 1'b0, 1'b0));
		table_rows.push_back(mk(32'h0001_0001, 32'h0100_0000, 1'b0, 1'b1));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i])
			send_item(table_rows[i]);

		// Random sets: mostly well-formed, some all missing, a few that overfill the store.
		while (items_sent < 700) begin
			kind = $urandom_range(0, 39);
			wide = $urandom_range(0, 2) == 0;
			same = $urandom_range(0, 9) == 0;
			fixed_beta = rand_beta(wide);
			if (kind == 0)
				len = $urandom_range(STORE_DEPTH - 1, STORE_DEPTH + 4);
			else
				len = $urandom_range(1, 8);
			quiet = items_sent > 600;
			for (int k = 0; k < len; k++)
				send_item(mk(same ? fixed_beta : rand_beta(wide), rand_se($urandom_range(0, 2) == 0),
					kind == 1 || $urandom_range(0, 6) == 0, k == len - 1));
		end
		s_tvalid <= 1'b0;

		while (pending_pools.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
hw/rtl/ipr_pkg.sv
hw/rtl/ipr_ram.sv
hw/rtl/ipr_div.sv
hw/rtl/ipr_sqrt.sv
hw/rtl/imputation_pooling_rubin.sv
dv/tb_top.sv
